/* rtl/lsmp_pkg.sv */
// Shared types, codes and the speed table of the limit switch motor positioner.
package lsmp_pkg;

   // Position width of the target, current and preset fields
   localparam int PosBits      = 10;
   localparam int DeadbandBits = 6;
   localparam int LossBits     = 4;
   localparam int DutyBits     = 8;
   localparam int ModeBits     = 3;
   localparam int LevelBits    = 3;

   // Stream and register port widths
   localparam int ReqDataBits = 32;
   localparam int RspDataBits = 24;
   localparam int CsrIdxBits  = 2;
   localparam int CsrDataBits = PosBits;

   // Item kinds carried in req_tuser
   localparam logic CmdRequest = 1'b0;
   localparam logic CmdTick    = 1'b1;

   // Run modes
   localparam logic [ModeBits-1:0] ModeGoto = 3'd0;
   localparam logic [ModeBits-1:0] ModeDown = 3'd1;
   localparam logic [ModeBits-1:0] ModeUp   = 3'd2;
   localparam logic [ModeBits-1:0] ModeIdle = 3'd3;

   // Register indexes on the csr port
   localparam logic [CsrIdxBits-1:0] CfgTopPosition = 2'd0;
   localparam logic [CsrIdxBits-1:0] CfgDeadband    = 2'd1;
   localparam logic [CsrIdxBits-1:0] CfgLossLimit   = 2'd2;

   // Register reset values
   localparam logic [PosBits-1:0]      TopPositionReset = 10'd397;
   localparam logic [DeadbandBits-1:0] DeadbandReset    = 6'd3;
   localparam logic [LossBits-1:0]     LossLimitReset   = 4'd2;
   localparam logic [LossBits-1:0]     LossCountMax     = {LossBits{1'b1}};

   typedef struct packed {
      logic                    command;
      logic [ModeBits-1:0]     run_mode;
      logic [PosBits-1:0]      target_position;
      logic [PosBits-1:0]      current_position;
      logic                    upper_limit_hit;
      logic                    lower_limit_hit;
      logic                    link_ok;
      logic                    driver_fault;
      logic [LevelBits-1:0]    speed_level;
      logic                    fast_alt;
   } req_item_type;

   typedef struct packed {
      logic                 done_res;
      logic                 direction_up;
      logic                 brake;
      logic                 driver_enable;
      logic                 reset_pulse;
      logic [DutyBits-1:0]  duty;
      logic                 preset_valid;
      logic [PosBits-1:0]   preset_value;
   } rsp_item_type;

   typedef struct packed {
      logic [LossBits-1:0]  loss_count;
      logic [DutyBits-1:0]  duty;
      logic                 dir_up;
      logic                 brake;
      logic                 enable;
   } motor_state_type;

   typedef struct packed {
      logic [PosBits-1:0]      upper_preset;
      logic [DeadbandBits-1:0] deadband;
      logic [LossBits-1:0]     loss_limit;
   } cfg_type;

   // Duty for each speed level; undefined levels give zero
   function automatic logic [DutyBits-1:0] speed_duty(input logic [LevelBits-1:0] level,
                                                      input logic alt);
      logic [DutyBits-1:0] d;
      unique case (level)
         3'd0:    d = alt ? 8'd95 : 8'd130;
         3'd1:    d = 8'd56;
         3'd2:    d = 8'd42;
         3'd3:    d = 8'd33;
         3'd4:    d = 8'd40;
         3'd5:    d = 8'd110;
         default: d = '0;
      endcase
      return d;
   endfunction

endpackage

/* rtl/lsmp_in_reg.sv */
// Input register stage: captures one request or tick transfer and holds it.
module lsmp_in_reg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lsmp_pkg::ReqDataBits-1:0]    req_tdata,
   input  logic                                req_tuser,
   input  logic                                advance,
   output logic                                item_valid,
   output lsmp_pkg::req_item_type              item
);

   logic                   valid_ff;
   logic                   valid_in;
   lsmp_pkg::req_item_type item_ff;
   lsmp_pkg::req_item_type item_in;
   logic                   take;

   // Free when empty or when the held item moves on this cycle
   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   // Unpack the transfer, lowest field first
   always_comb begin
      item_in                  = item_ff;
      if (take) begin
         item_in.command          = req_tuser;
         item_in.run_mode         = req_tdata[2:0];
         item_in.target_position  = req_tdata[12:3];
         item_in.current_position = req_tdata[22:13];
         item_in.upper_limit_hit  = req_tdata[23];
         item_in.lower_limit_hit  = req_tdata[24];
         item_in.link_ok          = req_tdata[25];
         item_in.driver_fault     = req_tdata[26];
         item_in.speed_level      = req_tdata[29:27];
         item_in.fast_alt         = req_tdata[30];
      end
      valid_in = take || (valid_ff && !advance);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* rtl/lsmp_decide.sv */
// Decision logic: next motor state and the result for one item.
module lsmp_decide (
   input  lsmp_pkg::req_item_type    item,
   input  lsmp_pkg::motor_state_type cur_state,
   input  lsmp_pkg::cfg_type         cfg,
   output lsmp_pkg::motor_state_type next_state,
   output lsmp_pkg::rsp_item_type    result
);

   logic [lsmp_pkg::PosBits:0]       cur_ext;
   logic [lsmp_pkg::PosBits:0]       tgt_ext;
   logic [lsmp_pkg::PosBits:0]       db_ext;
   logic                             want_up;
   logic                             want_down;
   logic [lsmp_pkg::DutyBits-1:0]    table_duty;
   logic [lsmp_pkg::LossBits-1:0]    cnt_sat;

   // Exact compares with one extra bit, no wrap
   assign cur_ext = {1'b0, item.current_position};
   assign tgt_ext = {1'b0, item.target_position};
   assign db_ext  = {{(lsmp_pkg::PosBits + 1 - lsmp_pkg::DeadbandBits){1'b0}}, cfg.deadband};

   assign table_duty = lsmp_pkg::speed_duty(item.speed_level, item.fast_alt);
   assign cnt_sat    = (cur_state.loss_count == lsmp_pkg::LossCountMax) ?
                       cur_state.loss_count :
                       cur_state.loss_count + lsmp_pkg::LossBits'(1);

   // Wanted direction from the run mode
   always_comb begin
      want_up   = 1'b0;
      want_down = 1'b0;
      unique case (item.run_mode)
         lsmp_pkg::ModeGoto: begin
            if (tgt_ext > cur_ext + db_ext) begin
               want_up = 1'b1;
            end else if (tgt_ext + db_ext < cur_ext) begin
               want_down = 1'b1;
            end
         end
         lsmp_pkg::ModeDown: want_down = 1'b1;
         lsmp_pkg::ModeUp:   want_up   = 1'b1;
         default: begin
            want_up   = 1'b0;
            want_down = 1'b0;
         end
      endcase
   end

   // Update the driver state and build the result
   always_comb begin
      next_state          = cur_state;
      result              = '0;
      if (item.command == lsmp_pkg::CmdTick) begin
         next_state.loss_count = cnt_sat;
         if (cnt_sat > cfg.loss_limit) begin
            next_state.duty = '0;
         end
      end else begin
         next_state.loss_count = '0;
         if (!item.link_ok) begin
            next_state.brake = 1'b1;
            next_state.duty  = '0;
            result.done_res  = 1'b1;
         end else if (item.run_mode > lsmp_pkg::ModeIdle) begin
            // Unknown mode: power off, hold the rest
            next_state.duty = '0;
         end else if (want_up && item.upper_limit_hit) begin
            result.preset_valid = 1'b1;
            result.preset_value = cfg.upper_preset;
            next_state.brake    = 1'b1;
            next_state.duty     = '0;
            result.done_res     = 1'b1;
         end else if (want_down && item.lower_limit_hit) begin
            result.preset_valid = 1'b1;
            next_state.brake    = 1'b1;
            next_state.duty     = '0;
            result.done_res     = 1'b1;
         end else if (want_up || want_down) begin
            next_state.enable  = 1'b1;
            next_state.dir_up  = want_up;
            next_state.brake   = 1'b0;
            next_state.duty    = table_duty;
            result.reset_pulse = (table_duty != '0) && item.driver_fault;
         end else begin
            next_state.brake = 1'b1;
            next_state.duty  = '0;
            result.done_res  = 1'b1;
         end
      end
      result.direction_up  = next_state.dir_up;
      result.brake         = next_state.brake;
      result.driver_enable = next_state.enable;
      result.duty          = next_state.duty;
   end

endmodule

/* rtl/limit_switch_motor_positioner_core.sv */
// Top level of the limit switch motor positioner: registers, state and result stage.
//
//   channel  direction  handshake            payload
//   req_     in         tvalid/tready        tdata: mode, positions, switches, speed; tuser: kind
//   rsp_     out        tvalid/tready        tdata: done, direction, brake, enable, pulse, duty,
//                                            preset
//   csr_     in         we (no wait)         index, wdata
//
// One item per cycle while rsp_ is not stalled; a result is offered on rsp_ once its request
// or tick transfer has passed the input register, then decision logic into the result register.
// Reset clears the control and motor state and loads the register defaults.
// A stalled rsp_ side holds the result; the input register still takes one more item.
module limit_switch_motor_positioner_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [2:0] run_mode, [12:3] target_position, [22:13] current_position, [23] upper_limit_hit,
   // [24] lower_limit_hit, [25] link_ok, [26] driver_fault, [29:27] speed_level,
   // [30] fast_alt, [31] zero
   input  logic [lsmp_pkg::ReqDataBits-1:0]   req_tdata,
   // [0] command
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] done_res, [1] direction_up, [2] brake, [3] driver_enable, [4] reset_pulse,
   // [12:5] duty, [13] preset_valid, [23:14] preset_value
   output logic [lsmp_pkg::RspDataBits-1:0]   rsp_tdata,
   input  logic                               csr_we,
   input  logic [lsmp_pkg::CsrIdxBits-1:0]    csr_index,
   input  logic [lsmp_pkg::CsrDataBits-1:0]   csr_wdata
);

   logic                       item_valid;
   lsmp_pkg::req_item_type     item;
   logic                       advance;
   lsmp_pkg::cfg_type          cfg_ff;
   lsmp_pkg::cfg_type          cfg_in;
   lsmp_pkg::motor_state_type  state_ff;
   lsmp_pkg::motor_state_type  state_in;
   lsmp_pkg::motor_state_type  state_next;
   lsmp_pkg::rsp_item_type     result;
   lsmp_pkg::rsp_item_type     out_ff;
   lsmp_pkg::rsp_item_type     out_in;
   logic                       out_valid_ff;
   logic                       out_valid_in;

   // Move the held item into the result register when it is free
   assign advance = item_valid && (!out_valid_ff || rsp_tready);

   lsmp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   lsmp_decide u_decide (
      .item       (item),
      .cur_state  (state_ff),
      .cfg        (cfg_ff),
      .next_state (state_next),
      .result     (result)
   );

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            lsmp_pkg::CfgTopPosition: cfg_in.upper_preset = csr_wdata;
            lsmp_pkg::CfgDeadband:
               cfg_in.deadband = csr_wdata[lsmp_pkg::DeadbandBits-1:0];
            lsmp_pkg::CfgLossLimit:
               cfg_in.loss_limit = csr_wdata[lsmp_pkg::LossBits-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // Commit state and result on each advance; drop the result on its transfer
   always_comb begin
      state_in     = advance ? state_next : state_ff;
      out_in       = advance ? result : out_ff;
      out_valid_in = advance || (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.upper_preset <= lsmp_pkg::TopPositionReset;
         cfg_ff.deadband     <= lsmp_pkg::DeadbandReset;
         cfg_ff.loss_limit   <= lsmp_pkg::LossLimitReset;
         state_ff            <= '0;
         out_valid_ff        <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.preset_value, out_ff.preset_valid, out_ff.duty,
                        out_ff.reset_pulse, out_ff.driver_enable, out_ff.brake,
                        out_ff.direction_up, out_ff.done_res};

   // A preset always comes with a braked, stopped motor and a done flag
   a_preset_brakes: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.preset_valid |->
         out_ff.brake && out_ff.done_res && (out_ff.duty == '0))
      else $error("preset without brake");

   // A driver reset pulse only while powering with nonzero duty
   a_pulse_powered: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.reset_pulse |->
         out_ff.driver_enable && !out_ff.brake && (out_ff.duty != '0))
      else $error("reset pulse while not powered");

   // A processed request clears the loss counter
   a_request_clears_loss: assert property (@(posedge clock) disable iff (reset)
      advance && (item.command == lsmp_pkg::CmdRequest) |=> state_ff.loss_count == '0)
      else $error("loss counter not cleared by request");

   // Results mirror the committed motor state
   a_result_tracks_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> (out_ff.duty == state_ff.duty) && (out_ff.brake == state_ff.brake) &&
                  (out_ff.direction_up == state_ff.dir_up))
      else $error("result differs from motor state");

endmodule

/* tb/positioner_checker.sv */
// Scoreboard for the motor positioner: mirrors registers and motor state, predicts, compares.
module positioner_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [lsmp_pkg::ReqDataBits-1:0]    req_tdata,
   input  logic                                req_tuser,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [lsmp_pkg::RspDataBits-1:0]    rsp_tdata,
   input  logic                                csr_we,
   input  logic [lsmp_pkg::CsrIdxBits-1:0]     csr_index,
   input  logic [lsmp_pkg::CsrDataBits-1:0]    csr_wdata,
   output int unsigned                         mismatch_count,
   output int unsigned                         outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   lsmp_pkg::cfg_type         settings;
   lsmp_pkg::motor_state_type motor;
   lsmp_pkg::rsp_item_type    motor_outputs_q[$];

   // Print one line per mismatch and count it
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] due);
      $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, due);
      mismatch_count++;
   endtask

   // Advance the mirrored motor state by one request or tick and return the outputs
   function automatic lsmp_pkg::rsp_item_type positioner_step(
      input lsmp_pkg::req_item_type it);
      lsmp_pkg::rsp_item_type        res;
      int                            tgt, pos, band, want;
      logic [lsmp_pkg::DutyBits-1:0] table_duty;
      logic                          powering, halt;
      res        = '0;
      want       = 0;
      powering   = 1'b0;
      halt       = 1'b0;
      table_duty = '0;
      tgt        = int'(it.target_position);
      pos        = int'(it.current_position);
      band       = int'(settings.deadband);
      if (it.command == lsmp_pkg::CmdTick) begin
         // count missed requests, saturating, and cut the duty past the limit
         if (motor.loss_count != lsmp_pkg::LossCountMax)
            motor.loss_count = motor.loss_count + lsmp_pkg::LossBits'(1);
         if (motor.loss_count > settings.loss_limit)
            motor.duty = '0;
      end else begin
         motor.loss_count = '0;
         if (!it.link_ok) begin
            halt = 1'b1;
         end else begin
            case (it.run_mode)
               lsmp_pkg::ModeGoto: begin
                  if (tgt > pos + band)
                     want = 1;
                  else if (tgt + band < pos)
                     want = -1;
               end
               lsmp_pkg::ModeDown: want = -1;
               lsmp_pkg::ModeUp:   want = 1;
               default:            want = 0;
            endcase
            if (it.run_mode > lsmp_pkg::ModeIdle) begin
               motor.duty = '0;
            end else if (want == 1 && it.upper_limit_hit) begin
               res.preset_valid = 1'b1;
               res.preset_value = settings.upper_preset;
               halt             = 1'b1;
            end else if (want == -1 && it.lower_limit_hit) begin
               res.preset_valid = 1'b1;
               res.preset_value = '0;
               halt             = 1'b1;
            end else if (want != 0) begin
               motor.enable = 1'b1;
               motor.dir_up = (want == 1);
               motor.brake  = 1'b0;
               powering     = 1'b1;
            end else begin
               halt = 1'b1;
            end
            // pick the duty from the speed table; a fault pulses the driver reset
            if (powering) begin
               case (it.speed_level)
                  3'd0:    table_duty = it.fast_alt ? 8'd95 : 8'd130;
                  3'd1:    table_duty = 8'd56;
                  3'd2:    table_duty = 8'd42;
                  3'd3:    table_duty = 8'd33;
                  3'd4:    table_duty = 8'd40;
                  3'd5:    table_duty = 8'd110;
                  default: table_duty = '0;
               endcase
               if (table_duty != '0 && it.driver_fault) begin
                  res.reset_pulse = 1'b1;
                  motor.enable    = 1'b1;
               end
               motor.duty = table_duty;
            end
         end
         // brake and report done
         if (halt) begin
            motor.brake  = 1'b1;
            motor.duty   = '0;
            res.done_res = 1'b1;
         end
      end
      res.direction_up  = motor.dir_up;
      res.brake         = motor.brake;
      res.driver_enable = motor.enable;
      res.duty          = motor.duty;
      return res;
   endfunction

   always @(posedge clock) begin : watch
      lsmp_pkg::req_item_type it;
      lsmp_pkg::rsp_item_type seen, due;
      if (reset) begin
         motor    = '0;
         settings = '{upper_preset: lsmp_pkg::TopPositionReset,
                      deadband: lsmp_pkg::DeadbandReset,
                      loss_limit: lsmp_pkg::LossLimitReset};
         motor_outputs_q.delete();
      end else begin
         // mirror register writes
         if (csr_we) begin
            case (csr_index)
               lsmp_pkg::CfgTopPosition:
                  settings.upper_preset = csr_wdata[lsmp_pkg::PosBits-1:0];
               lsmp_pkg::CfgDeadband:
                  settings.deadband = csr_wdata[lsmp_pkg::DeadbandBits-1:0];
               lsmp_pkg::CfgLossLimit:
                  settings.loss_limit = csr_wdata[lsmp_pkg::LossBits-1:0];
               default: ;
            endcase
         end
         // compare each result transfer with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            seen.done_res      = rsp_tdata[0];
            seen.direction_up  = rsp_tdata[1];
            seen.brake         = rsp_tdata[2];
            seen.driver_enable = rsp_tdata[3];
            seen.reset_pulse   = rsp_tdata[4];
            seen.duty          = rsp_tdata[12:5];
            seen.preset_valid  = rsp_tdata[13];
            seen.preset_value  = rsp_tdata[23:14];
            if (motor_outputs_q.size() == 0) begin
               report_mismatch("unexpected result", 32'(rsp_tdata), 32'(0));
            end else begin
               due = motor_outputs_q.pop_front();
               if (seen.done_res !== due.done_res)
                  report_mismatch("done_res", 32'(seen.done_res), 32'(due.done_res));
               if (seen.direction_up !== due.direction_up)
                  report_mismatch("direction_up", 32'(seen.direction_up),
                                  32'(due.direction_up));
               if (seen.brake !== due.brake)
                  report_mismatch("brake", 32'(seen.brake), 32'(due.brake));
               if (seen.driver_enable !== due.driver_enable)
                  report_mismatch("driver_enable", 32'(seen.driver_enable),
                                  32'(due.driver_enable));
               if (seen.reset_pulse !== due.reset_pulse)
                  report_mismatch("reset_pulse", 32'(seen.reset_pulse),
                                  32'(due.reset_pulse));
               if (seen.duty !== due.duty)
                  report_mismatch("duty", 32'(seen.duty), 32'(due.duty));
               if (seen.preset_valid !== due.preset_valid)
                  report_mismatch("preset_valid", 32'(seen.preset_valid),
                                  32'(due.preset_valid));
               if (seen.preset_value !== due.preset_value)
                  report_mismatch("preset_value", 32'(seen.preset_value),
                                  32'(due.preset_value));
            end
         end
         // predict on each request transfer
         if (req_tvalid && req_tready) begin
            it.command          = req_tuser;
            it.run_mode         = req_tdata[2:0];
            it.target_position  = req_tdata[12:3];
            it.current_position = req_tdata[22:13];
            it.upper_limit_hit  = req_tdata[23];
            it.lower_limit_hit  = req_tdata[24];
            it.link_ok          = req_tdata[25];
            it.driver_fault     = req_tdata[26];
            it.speed_level      = req_tdata[29:27];
            it.fast_alt         = req_tdata[30];
            motor_outputs_q.push_back(positioner_step(it));
         end
      end
      outstanding <= motor_outputs_q.size();
   end

endmodule

/* tb/tb.sv */
// Testbench top for the motor positioner: clock, reset, stimulus, flow control and verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CycleLimit    = 300000;
   localparam int unsigned HoldOffCycles = 200;
   localparam int unsigned PhaseItems    = 110;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [lsmp_pkg::ReqDataBits-1:0]    req_tdata;
   logic                                req_tuser;
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   logic [lsmp_pkg::RspDataBits-1:0]    rsp_tdata;
   logic                                csr_we;
   logic [lsmp_pkg::CsrIdxBits-1:0]     csr_index;
   logic [lsmp_pkg::CsrDataBits-1:0]    csr_wdata;

   int unsigned mismatch_count;
   int unsigned outstanding;
   int unsigned cycle_count = 0;
   int          band_now;
   bit          steady_flow;
   bit          hold_off_request;
   bit          hold_off_served;

   limit_switch_motor_positioner_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   positioner_checker result_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CycleLimit);
      $display("[limit_switch_motor_positioner_core] ERROR");
      $finish;
   end

   // Offer one item, hold it until the transfer, then sometimes idle for a random gap
   task automatic send_item(input lsmp_pkg::req_item_type it);
      int unsigned pick, gap;
      req_tvalid <= 1'b1;
      req_tuser  <= it.command;
      req_tdata  <= {1'b0, it.fast_alt, it.speed_level, it.driver_fault, it.link_ok,
                     it.lower_limit_hit, it.upper_limit_hit, it.current_position,
                     it.target_position, it.run_mode};
      do @(posedge clock); while (!req_tready);
      pick = $urandom_range(0, 99);
      if (steady_flow || pick < 60)
         gap = 0;
      else if (pick < 90)
         gap = $urandom_range(1, 3);
      else
         gap = $urandom_range(8, 30);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every predicted result has come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   // Write all three registers on consecutive cycles while the block is idle
   task automatic load_settings(input logic [lsmp_pkg::PosBits-1:0] top_pos,
                                input logic [lsmp_pkg::DeadbandBits-1:0] band,
                                input logic [lsmp_pkg::LossBits-1:0] limit);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= lsmp_pkg::CfgTopPosition;
      csr_wdata <= top_pos;
      @(posedge clock);
      csr_index <= lsmp_pkg::CfgDeadband;
      csr_wdata <= lsmp_pkg::CsrDataBits'(band);
      @(posedge clock);
      csr_index <= lsmp_pkg::CfgLossLimit;
      csr_wdata <= lsmp_pkg::CsrDataBits'(limit);
      @(posedge clock);
      csr_we <= 1'b0;
      band_now = int'(band);
   endtask

   function automatic lsmp_pkg::req_item_type request(
      input logic [lsmp_pkg::ModeBits-1:0] mode,
      input logic [lsmp_pkg::PosBits-1:0] tgt,
      input logic [lsmp_pkg::PosBits-1:0] pos,
      input logic up_hit, input logic down_hit,
      input logic link, input logic fault,
      input logic [lsmp_pkg::LevelBits-1:0] level,
      input logic alt);
      return '{command: lsmp_pkg::CmdRequest, run_mode: mode, target_position: tgt,
               current_position: pos, upper_limit_hit: up_hit, lower_limit_hit: down_hit,
               link_ok: link, driver_fault: fault, speed_level: level, fast_alt: alt};
   endfunction

   // Mostly valid requests, half of them with targets near the deadband edges
   function automatic lsmp_pkg::req_item_type random_request();
      lsmp_pkg::req_item_type it;
      int unsigned            pick;
      int                     tgt;
      it         = $urandom;
      it.command = lsmp_pkg::CmdRequest;
      pick       = $urandom_range(0, 99);
      if (pick < 40)
         it.run_mode = lsmp_pkg::ModeGoto;
      else if (pick < 55)
         it.run_mode = lsmp_pkg::ModeDown;
      else if (pick < 70)
         it.run_mode = lsmp_pkg::ModeUp;
      else if (pick < 82)
         it.run_mode = lsmp_pkg::ModeIdle;
      else
         it.run_mode = lsmp_pkg::ModeBits'($urandom_range(4, 7));
      pick = $urandom_range(0, 19);
      if (pick == 0)
         it.current_position = '0;
      else if (pick == 1)
         it.current_position = '1;
      if ($urandom_range(0, 1)) begin
         tgt = int'(it.current_position) + int'($urandom_range(0, 2 * band_now + 4))
               - band_now - 2;
         if (tgt < 0)
            tgt = 0;
         if (tgt > 1023)
            tgt = 1023;
         it.target_position = lsmp_pkg::PosBits'(tgt);
      end
      it.upper_limit_hit = ($urandom_range(0, 3) == 0);
      it.lower_limit_hit = ($urandom_range(0, 3) == 0);
      it.link_ok         = ($urandom_range(0, 11) != 0);
      it.driver_fault    = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 9) != 0)
         it.speed_level = lsmp_pkg::LevelBits'($urandom_range(0, 5));
      return it;
   endfunction

   // Requests, some followed by a run of ticks, sometimes long enough to saturate
   task automatic run_phase(input int unsigned count);
      int unsigned            sent, ticks, pick;
      lsmp_pkg::req_item_type tick;
      sent = 0;
      while (sent < count) begin
         send_item(random_request());
         sent++;
         pick = $urandom_range(0, 99);
         if (pick < 70)
            ticks = 0;
         else if (pick < 90)
            ticks = $urandom_range(1, 4);
         else
            ticks = $urandom_range(5, 20);
         repeat (ticks) begin
            tick         = $urandom;
            tick.command = lsmp_pkg::CmdTick;
            send_item(tick);
            sent++;
         end
      end
   endtask

   // Result side: random stalls, one long hold-off on request, steady when asked
   initial begin : rsp_side
      int unsigned span, pick;
      rsp_tready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_request && !hold_off_served) begin
            rsp_tready      <= 1'b0;
            span            = HoldOffCycles;
            hold_off_served = 1'b1;
         end else if (steady_flow) begin
            rsp_tready <= 1'b1;
            span       = 1;
         end else begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
               rsp_tready <= 1'b1;
               span       = $urandom_range(1, 8);
            end else if (pick < 9) begin
               rsp_tready <= 1'b0;
               span       = $urandom_range(1, 3);
            end else begin
               rsp_tready <= 1'b0;
               span       = $urandom_range(10, 40);
            end
         end
         repeat (span) @(posedge clock);
      end
   end

   initial begin : stimulus
      lsmp_pkg::req_item_type tick;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      req_tuser        = lsmp_pkg::CmdRequest;
      csr_we           = 1'b0;
      csr_index        = lsmp_pkg::CfgTopPosition;
      csr_wdata        = '0;
      steady_flow      = 1'b0;
      hold_off_request = 1'b0;
      band_now         = int'(lsmp_pkg::DeadbandReset);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, position extremes and deadband edges
      send_item(request(lsmp_pkg::ModeGoto, 10'd1023, 10'd0,
                        1'b0, 1'b0, 1'b1, 1'b0, 3'd0, 1'b0));
      send_item(request(lsmp_pkg::ModeGoto, 10'd0, 10'd1023,
                        1'b0, 1'b0, 1'b1, 1'b0, 3'd0, 1'b1));
      send_item(request(lsmp_pkg::ModeGoto, 10'd10, 10'd7,
                        1'b0, 1'b0, 1'b1, 1'b0, 3'd1, 1'b0));
      send_item(request(lsmp_pkg::ModeGoto, 10'd11, 10'd7,
                        1'b0, 1'b0, 1'b1, 1'b0, 3'd1, 1'b0));
      send_item(request(lsmp_pkg::ModeGoto, 10'd4, 10'd7,
                        1'b0, 1'b0, 1'b1, 1'b0, 3'd2, 1'b0));
      send_item(request(lsmp_pkg::ModeGoto, 10'd3, 10'd7,
                        1'b0, 1'b0, 1'b1, 1'b0, 3'd2, 1'b0));
      // limit switches preset the counter and brake
      send_item(request(lsmp_pkg::ModeUp, 10'd500, 10'd600,
                        1'b1, 1'b0, 1'b1, 1'b0, 3'd3, 1'b0));
      send_item(request(lsmp_pkg::ModeDown, 10'd500, 10'd600,
                        1'b0, 1'b1, 1'b1, 1'b0, 3'd3, 1'b0));
      // opposite switch does not stop the move; fault pulses the reset
      send_item(request(lsmp_pkg::ModeUp, 10'd0, 10'd0,
                        1'b0, 1'b1, 1'b1, 1'b1, 3'd4, 1'b0));
      send_item(request(lsmp_pkg::ModeDown, 10'd0, 10'd0,
                        1'b1, 1'b0, 1'b1, 1'b0, 3'd5, 1'b1));
      send_item(request(lsmp_pkg::ModeIdle, 10'd200, 10'd100,
                        1'b0, 1'b0, 1'b1, 1'b0, 3'd0, 1'b0));
      // link lost overrides the mode
      send_item(request(lsmp_pkg::ModeUp, 10'd1023, 10'd0,
                        1'b1, 1'b1, 1'b0, 1'b1, 3'd0, 1'b0));
      // unknown modes power off without done
      send_item(request(lsmp_pkg::ModeBits'(4), 10'd900, 10'd10,
                        1'b0, 1'b0, 1'b1, 1'b0, 3'd1, 1'b0));
      send_item(request(lsmp_pkg::ModeBits'(5), 10'd10, 10'd900,
                        1'b1, 1'b0, 1'b1, 1'b1, 3'd2, 1'b1));
      send_item(request(lsmp_pkg::ModeBits'(6), 10'd0, 10'd1023,
                        1'b0, 1'b1, 1'b1, 1'b0, 3'd6, 1'b0));
      send_item(request(lsmp_pkg::ModeBits'(7), 10'd1023, 10'd1023,
                        1'b1, 1'b1, 1'b1, 1'b1, 3'd7, 1'b1));
      // undefined speed levels: zero duty, no pulse, not braked; then level 0 with a fault pulses
      send_item(request(lsmp_pkg::ModeUp, 10'd0, 10'd0,
                        1'b0, 1'b0, 1'b1, 1'b1, 3'd6, 1'b0));
      send_item(request(lsmp_pkg::ModeDown, 10'd0, 10'd0,
                        1'b0, 1'b0, 1'b1, 1'b1, 3'd7, 1'b1));
      send_item(request(lsmp_pkg::ModeUp, 10'd0, 10'd0,
                        1'b0, 1'b0, 1'b1, 1'b1, 3'd0, 1'b0));
      // ticks past the loss limit zero the duty
      send_item(request(lsmp_pkg::ModeUp, 10'd0, 10'd0,
                        1'b0, 1'b0, 1'b1, 1'b0, 3'd5, 1'b0));
      repeat (4) begin
         tick         = $urandom;
         tick.command = lsmp_pkg::CmdTick;
         send_item(tick);
      end

      // random phases over several register settings, extremes first
      load_settings(10'd1023, 6'd63, 4'd15);
      run_phase(PhaseItems);
      load_settings(10'd0, 6'd0, 4'd0);
      hold_off_request = 1'b1;
      run_phase(PhaseItems);
      load_settings(lsmp_pkg::PosBits'($urandom),
                    lsmp_pkg::DeadbandBits'($urandom_range(0, 8)),
                    lsmp_pkg::LossBits'($urandom));
      steady_flow = 1'b1;
      run_phase(PhaseItems);
      steady_flow = 1'b0;
      load_settings(lsmp_pkg::PosBits'($urandom), lsmp_pkg::DeadbandBits'($urandom),
                    lsmp_pkg::LossBits'($urandom));
      run_phase(PhaseItems);
      load_settings(lsmp_pkg::TopPositionReset,
                    lsmp_pkg::DeadbandBits'($urandom_range(0, 5)),
                    lsmp_pkg::LossBits'($urandom_range(0, 4)));
      run_phase(PhaseItems);

      // drain, then let any stray result show up
      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("[limit_switch_motor_positioner_core] OK");
      else
         $display("[limit_switch_motor_positioner_core] ERROR");
      $finish;
   end

endmodule
